// ===== hdl/cpdm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpdm_pkg
// Shared constants, types and the arctangent table for the phase difference map.
// ----------------------------------------------------------------------------
package cpdm_pkg;

  localparam int AngleSteps   = 16;
  localparam int FractionBits = 4;
  localparam int TableLen     = 24;
  localparam int StepCount    = (AngleSteps > TableLen) ? TableLen : AngleSteps;
  localparam int StepIdxW     = $clog2(TableLen);

  localparam int SampleW  = 16;
  localparam int ProdW    = 2 * SampleW;
  localparam int CrossW   = ProdW + 1;
  localparam int PreScale = 24;
  // headroom for the cordic gain on top of the scaled vector
  localparam int XyW      = CrossW + PreScale + 2;
  localparam int AngleW   = 34;
  localparam int AtanW    = 32;

  localparam logic signed [AngleW-1:0] PiUnits     = AngleW'(64'sd3373259426);
  localparam logic signed [AngleW-1:0] HalfPiUnits = AngleW'(64'sd1686629713);

  localparam int MagW      = AngleW - 1;
  localparam int ScaleVal  = 1000 << FractionBits;
  localparam int ScaleW    = $clog2(ScaleVal + 1);
  localparam int MulW      = MagW + ScaleW;
  localparam int AngleFrac = 30;
  localparam int RoundW    = MulW + 1 - AngleFrac;
  localparam int OutW      = 17;
  localparam int OutMax    = 65535;
  localparam int OutMin    = -65536;
  localparam int OutNegLim = 65536;
  localparam int SatW      = ((RoundW > OutW) ? RoundW : OutW) + 1;

  typedef struct packed {
    logic signed [SampleW-1:0] first_real;
    logic signed [SampleW-1:0] first_imag;
    logic signed [SampleW-1:0] second_real;
    logic signed [SampleW-1:0] second_imag;
  } in_item_t;

  typedef struct packed {
    logic signed [OutW-1:0] thermal_value;
  } out_item_t;

  typedef struct packed {
    logic                     hold;
    logic signed [XyW-1:0]    x;
    logic signed [XyW-1:0]    y;
    logic signed [AngleW-1:0] z;
  } angle_stage_t;

  // atan(2^-i) in units of 2^-30 rad, truncated
  function automatic logic [AtanW-1:0] atan_unit(input logic [StepIdxW-1:0] idx);
    logic [AtanW-1:0] val;
    unique case (idx)
      5'd0:    val = 32'h3243F6A8;
      5'd1:    val = 32'h1DAC6705;
      5'd2:    val = 32'h0FADBAFC;
      5'd3:    val = 32'h07F56EA6;
      5'd4:    val = 32'h03FEAB76;
      5'd5:    val = 32'h01FFD55B;
      5'd6:    val = 32'h00FFFAAA;
      5'd7:    val = 32'h007FFF55;
      5'd8:    val = 32'h003FFFEA;
      5'd9:    val = 32'h001FFFFD;
      5'd10:   val = 32'h000FFFFF;
      5'd11:   val = 32'h0007FFFF;
      5'd12:   val = 32'h0003FFFF;
      5'd13:   val = 32'h0001FFFF;
      5'd14:   val = 32'h0000FFFF;
      5'd15:   val = 32'h00007FFF;
      5'd16:   val = 32'h00003FFF;
      5'd17:   val = 32'h00001FFF;
      5'd18:   val = 32'h00000FFF;
      5'd19:   val = 32'h000007FF;
      5'd20:   val = 32'h000003FF;
      5'd21:   val = 32'h000001FF;
      5'd22:   val = 32'h000000FF;
      5'd23:   val = 32'h0000007F;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/cpdm_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpdm_in_if
// Valid/ready channel carrying one pair of complex samples.
// ----------------------------------------------------------------------------
interface cpdm_in_if ();
  logic                valid;
  logic                ready;
  cpdm_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/cpdm_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpdm_out_if
// Valid/ready channel carrying one scaled phase value.
// ----------------------------------------------------------------------------
interface cpdm_out_if ();
  logic                valid;
  logic                ready;
  cpdm_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/cpdm_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpdm_front
// Conjugate product of the two samples, quadrant fold and special cases.
// ----------------------------------------------------------------------------
module cpdm_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  cpdm_pkg::in_item_t      in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output cpdm_pkg::angle_stage_t  out_data
);

  logic v1, v2, v3;
  logic ready1, ready2, ready3;

  logic signed [cpdm_pkg::ProdW-1:0]  p_rr, p_ii, p_ir, p_ri;
  logic signed [cpdm_pkg::CrossW-1:0] re, im;
  cpdm_pkg::angle_stage_t             init_next;
  cpdm_pkg::angle_stage_t             init;

  logic signed [cpdm_pkg::CrossW-1:0] xa, ya;
  logic                               re_zero, im_zero, im_pos;

  assign ready3   = !v3 || out_ready;
  assign ready2   = !v2 || ready3;
  assign ready1   = !v1 || ready2;
  assign in_ready = ready1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (ready1) v1 <= in_valid;
      if (ready2) v2 <= v1;
      if (ready3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1) begin
      p_rr <= in_data.first_real * in_data.second_real;
      p_ii <= in_data.first_imag * in_data.second_imag;
      p_ir <= in_data.first_imag * in_data.second_real;
      p_ri <= in_data.first_real * in_data.second_imag;
    end
    if (ready2) begin
      re <= cpdm_pkg::CrossW'(p_rr) + cpdm_pkg::CrossW'(p_ii);
      im <= cpdm_pkg::CrossW'(p_ir) - cpdm_pkg::CrossW'(p_ri);
    end
    if (ready3) begin
      init <= init_next;
    end
  end

  always_comb begin
    re_zero = (re == '0);
    im_zero = (im == '0);
    im_pos  = !im[cpdm_pkg::CrossW-1] && !im_zero;
    xa      = re;
    ya      = im;
    init_next.hold = 1'b0;
    init_next.z    = '0;
    priority if (re_zero) begin
      init_next.hold = 1'b1;
      if (im_pos) begin
        init_next.z = cpdm_pkg::HalfPiUnits;
      end else if (!im_zero) begin
        init_next.z = -cpdm_pkg::HalfPiUnits;
      end
    end else if (im_zero) begin
      init_next.hold = 1'b1;
      if (re[cpdm_pkg::CrossW-1]) init_next.z = cpdm_pkg::PiUnits;
    end else if (re[cpdm_pkg::CrossW-1]) begin
      // left half plane: rotate by pi and start from +-pi
      xa = -re;
      ya = -im;
      init_next.z = im_pos ? cpdm_pkg::PiUnits : -cpdm_pkg::PiUnits;
    end else begin
      // right half plane: rotations start from zero
      init_next.z = '0;
    end
    init_next.x = cpdm_pkg::XyW'($signed({xa, {cpdm_pkg::PreScale{1'b0}}}));
    init_next.y = cpdm_pkg::XyW'($signed({ya, {cpdm_pkg::PreScale{1'b0}}}));
  end

  assign out_valid = v3;
  assign out_data  = init;

endmodule
`default_nettype wire

// ===== hdl/cpdm_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpdm_cell
// One vectoring rotation step; a row of these forms the angle pipeline.
// ----------------------------------------------------------------------------
module cpdm_cell (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [cpdm_pkg::StepIdxW-1:0]  step,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  cpdm_pkg::angle_stage_t         in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output cpdm_pkg::angle_stage_t         out_data
);

  logic                              valid;
  cpdm_pkg::angle_stage_t            stage;
  cpdm_pkg::angle_stage_t            stage_next;
  logic signed [cpdm_pkg::XyW-1:0]   dx, dy;
  logic signed [cpdm_pkg::AngleW-1:0] dz;
  logic                              y_pos;

  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      stage <= stage_next;
    end
  end

  always_comb begin
    // arithmetic shift is a floor shift
    dx    = in_data.y >>> step;
    dy    = in_data.x >>> step;
    dz    = {{(cpdm_pkg::AngleW-cpdm_pkg::AtanW){1'b0}}, cpdm_pkg::atan_unit(step)};
    y_pos = !in_data.y[cpdm_pkg::XyW-1] && (in_data.y != '0);
    stage_next = in_data;
    if (!in_data.hold) begin
      if (y_pos) begin
        stage_next.x = in_data.x + dx;
        stage_next.y = in_data.y - dy;
        stage_next.z = in_data.z + dz;
      end else begin
        stage_next.x = in_data.x - dx;
        stage_next.y = in_data.y + dy;
        stage_next.z = in_data.z - dz;
      end
    end
  end

  assign out_valid = valid;
  assign out_data  = stage;

  a_hold_passes: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_data.hold) |=>
      (out_valid && out_data.hold && out_data.z == $past(in_data.z)))
    else $error("held angle changed in cell");

  a_x_stays_pos: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !in_data.hold && in_data.x > 0) |=> (out_data.x > 0))
    else $error("x left the right half plane");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("cell holds a transaction after reset");

endmodule
`default_nettype wire

// ===== hdl/cpdm_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpdm_back
// Scales the angle by -1000, rounds, saturates and holds the output register.
// ----------------------------------------------------------------------------
module cpdm_back (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [cpdm_pkg::AngleW-1:0] in_angle,
  output logic                               out_valid,
  input  logic                               out_ready,
  output cpdm_pkg::out_item_t                out_data
);

  logic v1, v2, v3, v4;
  logic ready1, ready2, ready3, ready4;

  logic                          pos1, pos2, pos3;
  logic [cpdm_pkg::MagW-1:0]     mag;
  logic [cpdm_pkg::MulW-1:0]     prod;
  logic [cpdm_pkg::RoundW-1:0]   rnd;
  logic [cpdm_pkg::MulW:0]       rnd_sum;
  logic [cpdm_pkg::SatW-1:0]     sat_r, sat_neg;
  logic signed [cpdm_pkg::OutW-1:0] value_next;
  logic signed [cpdm_pkg::OutW-1:0] value;
  logic                          z_pos, z_neg;

  assign ready4   = !v4 || out_ready;
  assign ready3   = !v3 || ready4;
  assign ready2   = !v2 || ready3;
  assign ready1   = !v1 || ready2;
  assign in_ready = ready1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (ready1) v1 <= in_valid;
      if (ready2) v2 <= v1;
      if (ready3) v3 <= v2;
      if (ready4) v4 <= v3;
    end
  end

  assign z_neg   = in_angle[cpdm_pkg::AngleW-1];
  assign z_pos   = !z_neg && (in_angle != '0);
  assign rnd_sum = {1'b0, prod} + (cpdm_pkg::MulW+1)'(1 << (cpdm_pkg::AngleFrac - 1));

  always_comb begin
    sat_r   = cpdm_pkg::SatW'(rnd);
    sat_neg = cpdm_pkg::SatW'(0) - sat_r;
    if (pos3) begin
      if (sat_r > cpdm_pkg::SatW'(cpdm_pkg::OutNegLim)) begin
        value_next = cpdm_pkg::OutW'(cpdm_pkg::OutMin);
      end else begin
        value_next = cpdm_pkg::OutW'(sat_neg);
      end
    end else begin
      if (sat_r > cpdm_pkg::SatW'(cpdm_pkg::OutMax)) begin
        value_next = cpdm_pkg::OutW'(cpdm_pkg::OutMax);
      end else begin
        value_next = cpdm_pkg::OutW'(sat_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready1) begin
      pos1 <= z_pos;
      mag  <= cpdm_pkg::MagW'(z_neg ? -in_angle : in_angle);
    end
    if (ready2) begin
      pos2 <= pos1;
      prod <= mag * cpdm_pkg::ScaleW'(cpdm_pkg::ScaleVal);
    end
    if (ready3) begin
      pos3 <= pos2;
      rnd  <= rnd_sum[cpdm_pkg::MulW:cpdm_pkg::AngleFrac];
    end
    if (ready4) begin
      value <= value_next;
    end
  end

  assign out_valid              = v4;
  assign out_data.thermal_value = value;

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output register valid after reset");

  a_sign_follows: assert property (@(posedge clk) disable iff (rst)
    (v3 && ready4 && pos3) |=> (value <= 0))
    else $error("positive angle gave a positive value");

  a_nonpos_follows: assert property (@(posedge clk) disable iff (rst)
    (v3 && ready4 && !pos3) |=> (value >= 0))
    else $error("non-positive angle gave a negative value");

endmodule
`default_nettype wire

// ===== hdl/complex_phase_difference_map.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// complex_phase_difference_map
// Per-pixel phase difference of two complex samples, scaled for a thermal map.
// ----------------------------------------------------------------------------
// Takes one pixel per clock and returns one 17-bit value per pixel, in order.
// Each value is -1000 times the angle of first * conj(second), with 4 fraction
// bits, rounded to nearest. A pixel passes the product, cross-sum and
// quadrant-fold registers, a register in each of the 16 rotation cells, then
// the magnitude, scaling, rounding and output registers. The pipeline is
// fully stallable; a stalled output only blocks new pixels once every stage
// ahead of it is occupied.
module complex_phase_difference_map (
  input  logic          clk,
  input  logic          rst,
  cpdm_in_if.sink       sample,
  cpdm_out_if.source    result
);

  logic                   link_valid [cpdm_pkg::StepCount+1];
  logic                   link_ready [cpdm_pkg::StepCount+1];
  cpdm_pkg::angle_stage_t link_data  [cpdm_pkg::StepCount+1];

  cpdm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .in_data   (sample.data),
    .out_valid (link_valid[0]),
    .out_ready (link_ready[0]),
    .out_data  (link_data[0])
  );

  for (genvar g = 0; g < cpdm_pkg::StepCount; g++) begin : g_cell
    cpdm_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .step      (cpdm_pkg::StepIdxW'(g)),
      .in_valid  (link_valid[g]),
      .in_ready  (link_ready[g]),
      .in_data   (link_data[g]),
      .out_valid (link_valid[g+1]),
      .out_ready (link_ready[g+1]),
      .out_data  (link_data[g+1])
    );
  end

  cpdm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (link_valid[cpdm_pkg::StepCount]),
    .in_ready  (link_ready[cpdm_pkg::StepCount]),
    .in_angle  (link_data[cpdm_pkg::StepCount].z),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_data  (result.data)
  );

endmodule
`default_nettype wire
